// ===== src/mps_pkg.sv =====
// shared types and constants for the midi pattern stamper
package mps_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_MIDI  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [0:0] CFG_LEN  = 1'b0;
    localparam logic [0:0] CFG_CLIP = 1'b1;

    localparam logic [7:0] KIND_MASK   = 8'hF0;
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [3:0] CH_MASK     = 4'hF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now_beat;
        logic [7:0]  midi_status;
        logic [6:0]  midi_data1;
        logic [6:0]  midi_data2;
        logic [2:0]  entry_index;
        logic [31:0] entry_beat;
        logic [31:0] entry_duration;
        logic [6:0]  entry_pitch;
        logic [3:0]  entry_channel;
        logic [6:0]  entry_velocity;
    } t_in;

    typedef struct packed {
        logic        event_valid;
        logic [7:0]  out_status;
        logic [7:0]  out_pitch;
        logic [6:0]  out_velocity;
        logic        note_dropped;
        logic        last;
    } t_out;

    // one pending note-off
    typedef struct packed {
        logic [31:0] beat;
        logic [7:0]  pitch;
        logic [3:0]  channel;
    } t_off;

endpackage

// ===== src/mps_alu.sv =====
// shared beat unit: due test against an instance start and saturating off-time add
module mps_alu (
    input  logic [31:0] i_now,
    input  logic [31:0] i_start,
    input  logic [31:0] i_at,
    input  logic [31:0] i_add_a,
    input  logic [31:0] i_add_b,
    output logic        o_due,
    output logic [31:0] o_sum
);
    logic [32:0] rel_beat;
    logic [32:0] sum_full;

    // exact signed difference: a beat before the start is never due
    assign rel_beat = {1'b0, i_now} - {1'b0, i_start};
    assign o_due    = !rel_beat[32] && (rel_beat[31:0] >= i_at);

    assign sum_full = {1'b0, i_add_a} + {1'b0, i_add_b};
    assign o_sum    = sum_full[32] ? 32'hFFFF_FFFF : sum_full[31:0];
endmodule

// ===== src/mps_off_ram.sv =====
// pending note-off store, one write and one registered read per cycle
module mps_off_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  mps_pkg::t_off i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output mps_pkg::t_off o_rdata
);
    mps_pkg::t_off mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

// ===== src/midi_pattern_stamper_core.sv =====
// top level of the midi pattern stamper: sequencer, instance state and pattern table
// One item is in work at a time; in_ready is high only while idle. A pattern write or a
// MIDI event gives one result. A tick with a nonzero pattern length visits each live
// instance in creation order: it opens the instance, reads each pending note-off from
// the off store (one read port) and emits or keeps it, starts each due pattern note-on
// and closes the instance; a stall on the result side holds the walk. All due tests and
// off-time sums go through one beat unit.
// Results leave through a one-deep holding stage and an output register so that the last
// flag can be set on the final result.
module midi_pattern_stamper_core #(
    parameter int MAX_INSTANCES = 4,
    parameter int MAX_NOTES     = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mps_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mps_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [0:0]    i_cfg_index,
    input  logic [3:0]    i_cfg_data
);
    localparam int IW    = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
    localparam int CW    = $clog2(MAX_INSTANCES + 1);
    localparam int PW    = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int NW    = $clog2(MAX_NOTES + 1);
    localparam int DEPTH = MAX_INSTANCES * MAX_NOTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_INST   = 7'b0000010,
        S_OFF_RD = 7'b0000100,
        S_OFF_EV = 7'b0001000,
        S_ON     = 7'b0010000,
        S_FIN    = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_st;

    logic [3:0] r_plen;
    logic       r_clip;

    logic [IW-1:0] r_ord   [MAX_INSTANCES];
    logic          r_live  [MAX_INSTANCES];
    logic [6:0]    r_trig  [MAX_INSTANCES];
    logic [31:0]   r_start [MAX_INSTANCES];
    logic [NW-1:0] r_nxt   [MAX_INSTANCES];
    logic          r_rel   [MAX_INSTANCES];
    logic [NW-1:0] r_cnt   [MAX_INSTANCES];
    logic [CW-1:0] r_n;

    logic [31:0] r_pb [MAX_NOTES];
    logic [31:0] r_pd [MAX_NOTES];
    logic [6:0]  r_pp [MAX_NOTES];
    logic [3:0]  r_pc [MAX_NOTES];
    logic [6:0]  r_pv [MAX_NOTES];

    logic [31:0]   r_now;
    logic [CW-1:0] r_j;
    logic [NW-1:0] r_k;
    logic [NW-1:0] r_w;
    logic          r_cut;
    logic          r_drop;

    logic          r_hold_v;
    mps_pkg::t_out r_hold;
    logic          r_ov;
    mps_pkg::t_out r_od;

    logic          in_acc;
    logic          out_acc;
    logic          can_emit;
    logic [IW-1:0] p;
    logic [NW-1:0] len;
    logic [PW-1:0] e;
    logic          alu_due;
    logic [31:0]   alu_sum;
    logic [31:0]   alu_at;
    mps_pkg::t_off rd;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    mps_pkg::t_off mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    on_pitch;
    logic          off_emit;
    logic          on_go;
    logic          retire;
    mps_pkg::t_out n_res;
    mps_pkg::t_out fin_res;
    logic [7:0]    in_kind;
    logic          new_on;
    logic          od_load;

    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = r_ov && i_out_ready;
    assign o_in_ready  = (r_st == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;
    assign can_emit    = !r_hold_v || !r_ov || out_acc;

    assign in_kind = i_in_data.midi_status & mps_pkg::KIND_MASK;
    assign new_on  = (i_in_data.opcode == mps_pkg::OP_MIDI) && (in_kind == mps_pkg::ST_NOTE_ON)
                  && (i_in_data.midi_data2 != '0);

    assign p   = r_ord[r_j[IW-1:0]];
    assign len = ({2'b00, r_plen} > 6'(MAX_NOTES)) ? NW'(MAX_NOTES) : NW'(r_plen);
    assign e   = PW'(r_nxt[p]);

    assign alu_at = (r_st == S_OFF_EV) ? rd.beat : r_pb[e];

    mps_alu u_alu (
        .i_now   (r_now),
        .i_start (r_start[p]),
        .i_at    (alu_at),
        .i_add_a (r_pb[e]),
        .i_add_b (r_pd[e]),
        .o_due   (alu_due),
        .o_sum   (alu_sum)
    );

    assign on_pitch = 8'({1'b0, r_trig[p]} + {1'b0, r_pp[e]} - {1'b0, r_pp[0]});
    assign off_emit = r_cut || alu_due;
    assign on_go    = !r_cut && (r_nxt[p] < len) && (r_w < NW'(MAX_NOTES)) && alu_due;
    assign retire   = (r_rel[p] && (r_w == '0))
                   || (!r_clip && (r_nxt[p] >= len) && (r_w == '0));

    // the output register takes a new result from the holding stage or the final one
    assign od_load = ((r_st == S_OFF_EV) && off_emit && can_emit && r_hold_v)
                  || ((r_st == S_ON) && on_go && can_emit && r_hold_v)
                  || ((r_st == S_DONE) && (!r_ov || out_acc));

    always_comb begin
        n_res = '0;
        n_res.event_valid = 1'b1;
        if (r_st == S_OFF_EV) begin
            n_res.out_status = mps_pkg::ST_NOTE_OFF | {4'h0, rd.channel & mps_pkg::CH_MASK};
            n_res.out_pitch  = rd.pitch;
        end else begin
            n_res.out_status   = mps_pkg::ST_NOTE_ON | {4'h0, r_pc[e] & mps_pkg::CH_MASK};
            n_res.out_pitch    = on_pitch;
            n_res.out_velocity = r_pv[e];
        end
    end

    always_comb begin
        fin_res = '0;
        if (r_hold_v) begin
            fin_res = r_hold;
        end else begin
            fin_res.note_dropped = r_drop;
        end
        fin_res.last = 1'b1;
    end

    always_comb begin
        mem_re    = (r_st == S_OFF_RD);
        mem_raddr = AW'(AW'(p) * AW'(MAX_NOTES) + AW'(r_k));
        mem_we    = 1'b0;
        mem_waddr = AW'(AW'(p) * AW'(MAX_NOTES) + AW'(r_w));
        mem_wdata = rd;
        if ((r_st == S_OFF_EV) && !off_emit) begin
            mem_we = 1'b1;
        end else if ((r_st == S_ON) && on_go && can_emit) begin
            mem_we            = 1'b1;
            mem_wdata.beat    = alu_sum;
            mem_wdata.pitch   = on_pitch;
            mem_wdata.channel = r_pc[e] & mps_pkg::CH_MASK;
        end
    end

    mps_off_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_off_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd)
    );

    // pattern table, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_data.opcode == mps_pkg::OP_WRITE)
            && (int'(i_in_data.entry_index) < MAX_NOTES)) begin
            r_pb[PW'(i_in_data.entry_index)] <= i_in_data.entry_beat;
            r_pd[PW'(i_in_data.entry_index)] <= i_in_data.entry_duration;
            r_pp[PW'(i_in_data.entry_index)] <= i_in_data.entry_pitch;
            r_pc[PW'(i_in_data.entry_index)] <= i_in_data.entry_channel;
            r_pv[PW'(i_in_data.entry_index)] <= i_in_data.entry_velocity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_plen   <= '0;
            r_clip   <= 1'b0;
            r_n      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_w      <= '0;
            r_cut    <= 1'b0;
            r_drop   <= 1'b0;
            r_now    <= '0;
            r_hold_v <= 1'b0;
            r_hold   <= '0;
            r_ov     <= 1'b0;
            r_od     <= '0;
            for (int q = 0; q < MAX_INSTANCES; q++) begin
                r_ord[q]   <= IW'(q);
                r_live[q]  <= 1'b0;
                r_trig[q]  <= '0;
                r_start[q] <= '0;
                r_nxt[q]   <= '0;
                r_rel[q]   <= 1'b0;
                r_cnt[q]   <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == mps_pkg::CFG_LEN) begin
                    r_plen <= i_cfg_data;
                end else begin
                    r_clip <= i_cfg_data[0];
                end
            end

            if (od_load) begin
                r_ov <= 1'b1;
            end else if (out_acc) begin
                r_ov <= 1'b0;
            end

            case (r_st)
                S_IDLE: begin
                    if (in_acc) begin
                        r_now  <= i_in_data.now_beat;
                        r_drop <= new_on && (r_n >= CW'(MAX_INSTANCES));
                        r_j    <= '0;
                        r_st   <= ((i_in_data.opcode == mps_pkg::OP_TICK) && (r_plen != '0))
                                  ? S_INST : S_DONE;
                        if (i_in_data.opcode == mps_pkg::OP_MIDI) begin
                            if (new_on) begin
                                if (r_n < CW'(MAX_INSTANCES)) begin
                                    r_live[r_ord[r_n[IW-1:0]]]  <= 1'b1;
                                    r_trig[r_ord[r_n[IW-1:0]]]  <= i_in_data.midi_data1;
                                    r_start[r_ord[r_n[IW-1:0]]] <= i_in_data.now_beat;
                                    r_nxt[r_ord[r_n[IW-1:0]]]   <= '0;
                                    r_rel[r_ord[r_n[IW-1:0]]]   <= 1'b0;
                                    r_cnt[r_ord[r_n[IW-1:0]]]   <= '0;
                                    r_n <= r_n + 1'b1;
                                end
                            end else if ((in_kind == mps_pkg::ST_NOTE_OFF)
                                      || (in_kind == mps_pkg::ST_NOTE_ON)) begin
                                for (int q = 0; q < MAX_INSTANCES; q++) begin
                                    if (r_live[q] && (r_trig[q] == i_in_data.midi_data1)) begin
                                        r_rel[q] <= 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                S_INST: begin
                    if (r_j >= r_n) begin
                        r_st <= S_DONE;
                    end else begin
                        r_k   <= '0;
                        r_w   <= '0;
                        r_cut <= r_clip && r_rel[p];
                        r_st  <= (r_cnt[p] != '0) ? S_OFF_RD : S_ON;
                    end
                end
                S_OFF_RD: begin
                    r_st <= S_OFF_EV;
                end
                S_OFF_EV: begin
                    if (!off_emit || can_emit) begin
                        if (off_emit) begin
                            if (r_hold_v) begin
                                r_od <= r_hold;
                            end
                            r_hold   <= n_res;
                            r_hold_v <= 1'b1;
                        end else begin
                            r_w <= r_w + 1'b1;
                        end
                        r_k  <= r_k + 1'b1;
                        r_st <= ((r_k + 1'b1) == r_cnt[p]) ? S_ON : S_OFF_RD;
                    end
                end
                S_ON: begin
                    if (!on_go) begin
                        r_st <= S_FIN;
                    end else if (can_emit) begin
                        if (r_hold_v) begin
                            r_od <= r_hold;
                        end
                        r_hold   <= n_res;
                        r_hold_v <= 1'b1;
                        r_w      <= r_w + 1'b1;
                        r_nxt[p] <= r_nxt[p] + 1'b1;
                    end
                end
                S_FIN: begin
                    r_cnt[p] <= r_w;
                    r_st     <= S_INST;
                    if (retire) begin
                        // retired id rotates to the free tail of the order list
                        for (int q = 0; q < MAX_INSTANCES - 1; q++) begin
                            if (CW'(q) >= r_j) begin
                                r_ord[q] <= r_ord[q + 1];
                            end
                        end
                        r_ord[MAX_INSTANCES - 1] <= p;
                        r_live[p] <= 1'b0;
                        r_n       <= r_n - 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!r_ov || out_acc) begin
                        r_od     <= fin_res;
                        r_hold_v <= 1'b0;
                        r_st     <= S_IDLE;
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CW'(MAX_INSTANCES))
        else $error("instance count above capacity");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_IDLE) |-> !r_hold_v)
        else $error("held result left behind when idle");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_st))
        else $error("sequencer state not one-hot");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_DONE && (!r_ov || out_acc)) |=> (r_ov && r_od.last))
        else $error("final result not marked last");
`endif

endmodule
